@@ hw/rtl/pfd_pkg.sv @@
// Shared types, widths and helpers for the filtered-derivative PID step.
`timescale 1ns / 1ps
package pfd_pkg;

  localparam int DATA_W  = 32;
  localparam int TAU_W   = 31;
  localparam int DT_W    = 20;
  localparam int ADDR_W  = 5;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 68;
  localparam int NUM_W   = 52;
  localparam int MAG_W   = 51;
  localparam int DEN_W   = 33;
  localparam int REM_W   = 34;
  localparam int QUO_W   = 31;
  localparam int CNT_W   = 5;

  localparam logic [2:0] REG_GAIN_P  = 3'd0;
  localparam logic [2:0] REG_GAIN_I  = 3'd1;
  localparam logic [2:0] REG_GAIN_D  = 3'd2;
  localparam logic [2:0] REG_TAU     = 3'd3;
  localparam logic [2:0] REG_OUT_MIN = 3'd4;
  localparam logic [2:0] REG_OUT_MAX = 3'd5;
  localparam logic [2:0] REG_TARGET  = 3'd6;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic        [TAU_W-1:0]  filter_tau;
    logic signed [DATA_W-1:0] out_min;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] target;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > PROD_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (x < PROD_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pfd_cfg.sv @@
// APB-style register file holding gains, filter constant, limits and setpoint.
`timescale 1ns / 1ps
module pfd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfd_pkg::ADDR_W-1:0]    paddr,
  input  logic [pfd_pkg::DATA_W-1:0]    pwdata,
  output logic [pfd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output pfd_pkg::cfg_t                 cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        pfd_pkg::REG_GAIN_P:  cfg.gain_p     <= pwdata;
        pfd_pkg::REG_GAIN_I:  cfg.gain_i     <= pwdata;
        pfd_pkg::REG_GAIN_D:  cfg.gain_d     <= pwdata;
        pfd_pkg::REG_TAU:     cfg.filter_tau <= pwdata[pfd_pkg::TAU_W-1:0];
        pfd_pkg::REG_OUT_MIN: cfg.out_min    <= pwdata;
        pfd_pkg::REG_OUT_MAX: cfg.out_max    <= pwdata;
        pfd_pkg::REG_TARGET:  cfg.target     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pfd_pkg::REG_GAIN_P:  prdata = cfg.gain_p;
      pfd_pkg::REG_GAIN_I:  prdata = cfg.gain_i;
      pfd_pkg::REG_GAIN_D:  prdata = cfg.gain_d;
      pfd_pkg::REG_TAU:     prdata = {1'b0, cfg.filter_tau};
      pfd_pkg::REG_OUT_MIN: prdata = cfg.out_min;
      pfd_pkg::REG_OUT_MAX: prdata = cfg.out_max;
      pfd_pkg::REG_TARGET:  prdata = cfg.target;
      default:              prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/pfd_mul.sv @@
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module pfd_mul (
  input  logic                                clk,
  input  logic signed [pfd_pkg::MUL_W-1:0]    a,
  input  logic signed [pfd_pkg::MUL_W-1:0]    b,
  output logic signed [pfd_pkg::PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ hw/rtl/pfd_div.sv @@
// Serial restoring divider: floor(mag * 2^16 / den) with overflow at 2^31.
`timescale 1ns / 1ps
module pfd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pfd_pkg::MAG_W-1:0]     mag,
  input  logic [pfd_pkg::DEN_W-1:0]     den,
  output pfd_pkg::div_res_t             res
);

  logic [pfd_pkg::REM_W-1:0] rem;
  logic [pfd_pkg::QUO_W-1:0] bits;
  logic [pfd_pkg::QUO_W-1:0] quo;
  logic [pfd_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic                      done;
  logic                      ovf;
  logic [pfd_pkg::REM_W-1:0] trial;
  logic                      fits;
  logic                      ovf_now;
  logic                      last_step;

  assign ovf_now   = mag >= {3'b000, den, 15'b0};
  assign trial     = {rem[pfd_pkg::REM_W-2:0], bits[pfd_pkg::QUO_W-1]};
  assign fits      = trial >= {1'b0, den};
  assign last_step = busy && (cnt == pfd_pkg::CNT_W'(1));
  assign res       = {done, ovf, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
    end else begin
      done <= start ? ovf_now : last_step;
      if (start) begin
        ovf  <= ovf_now;
        busy <= !ovf_now;
      end else if (last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= mag[48:15];
      bits <= {mag[14:0], 16'b0};
      cnt  <= pfd_pkg::CNT_W'(pfd_pkg::QUO_W);
    end else if (busy) begin
      rem  <= fits ? (trial - {1'b0, den}) : trial;
      bits <= {bits[pfd_pkg::QUO_W-2:0], 1'b0};
      quo  <= {quo[pfd_pkg::QUO_W-2:0], fits};
      cnt  <= cnt - pfd_pkg::CNT_W'(1);
    end
  end

endmodule

@@ hw/rtl/pid_filtered_derivative_step_top.sv @@
// PID step with trapezoidal integral and filtered derivative, Q16.16.
// The serial divider runs when the filter divides and ends early on overflow; it is skipped
// when filter_tau and elapsed_time are both zero. Items are handled one at a time: in_stall
// stays high until the result leaves ST_SUM. The pace is set by the 31-step serial divider
// behind one shared multiplier. A waiting result does not block the next accept.
// Reset (synchronous): controller state, out_valid, history and term registers cleared to zero.
`timescale 1ns / 1ps
module pid_filtered_derivative_step_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pfd_pkg::DATA_W-1:0]    measured,
  input  logic        [pfd_pkg::DT_W-1:0]      elapsed_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pfd_pkg::DATA_W-1:0]    drive,
  output logic                                 saturated,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [pfd_pkg::ADDR_W-1:0]    paddr,
  input  logic        [pfd_pkg::DATA_W-1:0]    pwdata,
  output logic        [pfd_pkg::DATA_W-1:0]    prdata,
  output logic                                 pready
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PREP   = 4'd1;
  localparam logic [3:0] ST_MUL_P  = 4'd2;
  localparam logic [3:0] ST_MUL_K  = 4'd3;
  localparam logic [3:0] ST_MUL_D1 = 4'd4;
  localparam logic [3:0] ST_MUL_I  = 4'd5;
  localparam logic [3:0] ST_MUL_D2 = 4'd6;
  localparam logic [3:0] ST_NUM    = 4'd7;
  localparam logic [3:0] ST_ABS    = 4'd8;
  localparam logic [3:0] ST_CHK    = 4'd9;
  localparam logic [3:0] ST_DIVW   = 4'd10;
  localparam logic [3:0] ST_SUM    = 4'd11;

  localparam int W  = pfd_pkg::DATA_W;
  localparam int PW = pfd_pkg::PROD_W;

  pfd_pkg::cfg_t     cfg;
  pfd_pkg::div_res_t div_res;

  logic [3:0] state;

  logic signed [W-1:0]                    meas;
  logic        [pfd_pkg::DT_W-1:0]        dt;
  logic signed [W-1:0]                    err;
  logic signed [W-1:0]                    half;
  logic signed [W-1:0]                    diff;
  logic signed [pfd_pkg::MUL_W-1:0]       coef;
  logic        [pfd_pkg::DEN_W-1:0]       den;
  logic signed [W-1:0]                    p;
  logic signed [W-1:0]                    k;
  logic signed [pfd_pkg::NUM_W-1:0]       t1;
  logic signed [pfd_pkg::NUM_W-1:0]       num;
  logic        [pfd_pkg::MAG_W-1:0]       num_abs;
  logic signed [W-1:0]                    integ;
  logic signed [W-1:0]                    hi;
  logic signed [W-1:0]                    lo;

  logic signed [W-1:0] last_error;
  logic signed [W-1:0] last_measured;
  logic signed [W-1:0] integral_term;
  logic signed [W-1:0] derivative_term;

  logic signed [pfd_pkg::MUL_W-1:0] mul_a;
  logic signed [pfd_pkg::MUL_W-1:0] mul_b;
  logic signed [PW-1:0]             prod;
  logic signed [pfd_pkg::NUM_W-1:0] t2;
  logic signed [pfd_pkg::NUM_W:0]   num_next;
  logic signed [W:0]                half_sum;
  logic signed [W-1:0]              sum;
  logic                             out_free;
  logic                             div_start;

  pfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign div_start = (state == ST_CHK) && (den != '0);

  pfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (num_abs),
    .den   (den),
    .res   (div_res)
  );

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (state)
      ST_MUL_P: begin
        mul_a = pfd_pkg::MUL_W'(cfg.gain_p);
        mul_b = pfd_pkg::MUL_W'(err);
      end
      ST_MUL_K: begin
        mul_a = pfd_pkg::MUL_W'(cfg.gain_i);
        mul_b = $signed({14'b0, dt});
      end
      ST_MUL_D1: begin
        mul_a = pfd_pkg::MUL_W'(cfg.gain_d);
        mul_b = pfd_pkg::MUL_W'(diff);
      end
      ST_MUL_I: begin
        mul_a = pfd_pkg::MUL_W'(k);
        mul_b = pfd_pkg::MUL_W'(half);
      end
      ST_MUL_D2: begin
        mul_a = coef;
        mul_b = pfd_pkg::MUL_W'(derivative_term);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign t2       = pfd_pkg::NUM_W'(prod >>> 16);
  assign num_next = (pfd_pkg::NUM_W+1)'(t1) + (pfd_pkg::NUM_W+1)'(t2);
  assign half_sum = (W+1)'(err) + (W+1)'(last_error);
  assign sum      = pfd_pkg::sat32(PW'(p) + PW'(integ) + PW'(derivative_term));

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      last_error      <= '0;
      last_measured   <= '0;
      integral_term   <= '0;
      derivative_term <= '0;
    end else begin
      if (out_valid && !out_stall && (state != ST_SUM)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP:   state <= ST_MUL_P;
        ST_MUL_P:  state <= ST_MUL_K;
        ST_MUL_K:  state <= ST_MUL_D1;
        ST_MUL_D1: state <= ST_MUL_I;
        ST_MUL_I:  state <= ST_MUL_D2;
        ST_MUL_D2: state <= ST_NUM;
        ST_NUM:    state <= ST_ABS;
        ST_ABS:    state <= ST_CHK;
        ST_CHK: begin
          state <= (den == '0) ? ST_SUM : ST_DIVW;
        end
        ST_DIVW: begin
          if (div_res.done) begin
            state <= ST_SUM;
            if (div_res.ovf) begin
              derivative_term <= num[pfd_pkg::NUM_W-1] ? pfd_pkg::S32_MIN : pfd_pkg::S32_MAX;
            end else if (num[pfd_pkg::NUM_W-1]) begin
              derivative_term <= W'(-$signed({1'b0, div_res.quo}));
            end else begin
              derivative_term <= W'($signed({1'b0, div_res.quo}));
            end
          end
        end
        ST_SUM: begin
          if (out_free) begin
            state         <= ST_IDLE;
            out_valid     <= 1'b1;
            integral_term <= integ;
            last_error    <= err;
            last_measured <= meas;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        meas <= measured;
        dt   <= elapsed_time;
      end
      ST_PREP: begin
        err  <= pfd_pkg::sat32(PW'(cfg.target) - PW'(meas));
        diff <= pfd_pkg::sat32(PW'(meas) - PW'(last_measured));
        coef <= $signed({2'b00, cfg.filter_tau, 1'b0}) - $signed({14'b0, dt});
        den  <= {1'b0, cfg.filter_tau, 1'b0} + {13'b0, dt};
      end
      ST_MUL_P: begin
        half <= half_sum[W:1];
      end
      ST_MUL_K: begin
        p <= pfd_pkg::sat32(prod >>> 16);
      end
      ST_MUL_D1: begin
        k <= pfd_pkg::sat32(prod >>> 16);
      end
      ST_MUL_I: begin
        t1 <= pfd_pkg::NUM_W'(prod >>> 15);
      end
      ST_MUL_D2: begin
        integ <= pfd_pkg::sat32(PW'(integral_term) + PW'(pfd_pkg::sat32(prod >>> 16)));
        hi    <= (p < cfg.out_max) ? pfd_pkg::sat32(PW'(cfg.out_max) - PW'(p)) : '0;
        lo    <= (p > cfg.out_min) ? pfd_pkg::sat32(PW'(cfg.out_min) - PW'(p)) : '0;
      end
      ST_NUM: begin
        num <= num_next[pfd_pkg::NUM_W-1:0];
      end
      ST_ABS: begin
        num_abs <= num[pfd_pkg::NUM_W-1] ? pfd_pkg::MAG_W'(-num) : pfd_pkg::MAG_W'(num);
        if (integ > hi) begin
          integ <= hi;
        end else if (integ < lo) begin
          integ <= lo;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          if (sum > cfg.out_max) begin
            drive     <= cfg.out_max;
            saturated <= 1'b1;
          end else if (sum < cfg.out_min) begin
            drive     <= cfg.out_min;
            saturated <= 1'b1;
          end else begin
            drive     <= sum;
            saturated <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
